FILE: rtl/key_debounce_long_press_macros.svh
// Assertion macros shared by the key debouncer RTL.
`ifndef KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH
`ifndef SYNTHESIS
`define KDLP_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("kdlp same-cycle check failed");
`define KDLP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("kdlp next-cycle check failed");
`else
`define KDLP_ASSERT_SAME(lbl, pre, post)
`define KDLP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/kdlp_pkg.sv
// Types, codes and constants of the key debouncer.
`default_nettype none
package kdlp_pkg;
	localparam int NUM_KEYS_DEF = 14;
	localparam int LEVEL_W = 14;
	localparam int INDEX_W = 4;
	localparam int FLAG_W = 5;
	localparam int CNT_W = 8;
	localparam int HOLD_W = 16;
	localparam int CFG_DATA_W = 16;

	localparam int FL_PRESSED = 0;
	localparam int FL_RELEASED = 1;
	localparam int FL_ON = 2;
	localparam int FL_LONG = 3;
	localparam int FL_CHANGED = 4;

	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd3;
	localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 16'd100;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_READ_CLEAR = 2'd1,
		OP_CLEAR_ALL = 2'd2
	} op_t;

	typedef enum logic {
		CFG_DEBOUNCE = 1'b0,
		CFG_LONG_PRESS = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_INIT = 3'b001,
		PH_IDLE = 3'b010,
		PH_ON = 3'b100
	} phase_t;

	typedef struct packed {
		logic tick;
		logic clr_all;
		logic [FLAG_W-1:0] mask;
	} cmd_t;

	typedef struct packed {
		logic [FLAG_W-1:0] flags;
		logic any_changed;
	} res_t;
endpackage
`default_nettype wire

FILE: rtl/kdlp_lane.sv
// One key's debounce and long-press state with its event flags.
`default_nettype none
`include "key_debounce_long_press_macros.svh"
module kdlp_lane (
	input wire logic clk,
	input wire logic arst_n,
	input wire kdlp_pkg::cmd_t cmd,
	input wire logic sel,
	input wire logic level,
	input wire logic [kdlp_pkg::CNT_W-1:0] debounce_limit,
	input wire logic [kdlp_pkg::HOLD_W-1:0] long_press_ticks,
	output logic [kdlp_pkg::FLAG_W-1:0] flags,
	output logic changed_next
);
	kdlp_pkg::phase_t phase_q, phase_d;
	logic [kdlp_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc, cnt_new;
	logic [kdlp_pkg::HOLD_W-1:0] hold_q, hold_d, hold_inc;
	logic [kdlp_pkg::FLAG_W-1:0] flags_q, flags_d, hit;

	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign hold_inc = hold_q + 1'b1;

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		hold_d = hold_q;
		flags_d = flags_q;
		cnt_new = '0;
		hit = flags_q & cmd.mask;
		if (cmd.tick) begin
			case (phase_q)
				kdlp_pkg::PH_IDLE: begin
					cnt_new = level ? cnt_inc : '0;
					if (cnt_new > debounce_limit) begin
						flags_d[kdlp_pkg::FL_CHANGED] = 1'b1;
						flags_d[kdlp_pkg::FL_PRESSED] = 1'b1;
						flags_d[kdlp_pkg::FL_ON] = 1'b1;
						hold_d = '0;
						cnt_d = '0;
						phase_d = kdlp_pkg::PH_ON;
					end else begin
						cnt_d = cnt_new;
					end
				end
				kdlp_pkg::PH_ON: begin
					if (hold_q < long_press_ticks) begin
						hold_d = hold_inc;
						if (hold_inc == long_press_ticks) begin
							flags_d[kdlp_pkg::FL_LONG] = 1'b1;
							flags_d[kdlp_pkg::FL_CHANGED] = 1'b1;
						end
					end
					cnt_new = level ? '0 : cnt_inc;
					if (cnt_new > debounce_limit) begin
						flags_d[kdlp_pkg::FL_CHANGED] = 1'b1;
						flags_d[kdlp_pkg::FL_RELEASED] = 1'b1;
						flags_d[kdlp_pkg::FL_ON] = 1'b0;
						hold_d = '0;
						cnt_d = '0;
						phase_d = kdlp_pkg::PH_IDLE;
					end else begin
						cnt_d = cnt_new;
					end
				end
				default: begin
					phase_d = kdlp_pkg::PH_IDLE;
				end
			endcase
		end else if (cmd.clr_all) begin
			flags_d = '0;
		end else if (sel) begin
			flags_d = flags_q & ~hit;
			// Clearing any of the four state flags that was set also drops changed.
			if (|hit[kdlp_pkg::FL_LONG:kdlp_pkg::FL_PRESSED]) begin
				flags_d[kdlp_pkg::FL_CHANGED] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kdlp_pkg::PH_INIT;
			cnt_q <= '0;
			hold_q <= '0;
			flags_q <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			hold_q <= hold_d;
			flags_q <= flags_d;
		end
	end

	assign flags = flags_q;
	assign changed_next = flags_d[kdlp_pkg::FL_CHANGED];

	`KDLP_ASSERT_NEXT(a_tick_leaves_init, cmd.tick, phase_q != kdlp_pkg::PH_INIT)
	`KDLP_ASSERT_NEXT(a_clear_all_empties, cmd.clr_all && !cmd.tick, flags_q == '0)
	`KDLP_ASSERT_SAME(a_idle_hold_zero, phase_q != kdlp_pkg::PH_ON, hold_q == '0)
endmodule
`default_nettype wire

FILE: rtl/kdlp_merge.sv
// Merges lane flags into one result and buffers it in a two-entry output stage.
`default_nettype none
`include "key_debounce_long_press_macros.svh"
module kdlp_merge #(
	parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [NUM_KEYS-1:0] sel,
	input wire logic [NUM_KEYS-1:0][kdlp_pkg::FLAG_W-1:0] lane_flags,
	input wire logic [NUM_KEYS-1:0] changed_next,
	output logic ready,
	output logic valid,
	input wire logic pop_ready,
	output kdlp_pkg::res_t res
);
	kdlp_pkg::res_t res_new, main_q, skid_q;
	logic main_valid_q, skid_valid_q, pop;

	always_comb begin
		res_new.flags = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			res_new.flags = res_new.flags | (lane_flags[k] & {kdlp_pkg::FLAG_W{sel[k]}});
		end
		res_new.any_changed = |changed_next;
	end

	assign pop = main_valid_q && pop_ready;
	assign ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				skid_q <= res_new;
			end else begin
				main_q <= res_new;
			end
		end else if (push) begin
			skid_q <= res_new;
		end
	end

	assign valid = main_valid_q;
	assign res = main_q;

	`KDLP_ASSERT_SAME(a_skid_behind_main, skid_valid_q, main_valid_q)
	`KDLP_ASSERT_NEXT(a_push_lands, push && !main_valid_q, main_valid_q)
	`KDLP_ASSERT_NEXT(a_held_stays, main_valid_q && !pop_ready, main_valid_q)
endmodule
`default_nettype wire

FILE: rtl/key_debounce_long_press.sv
// Key bank debouncer with long-press detection: one lane per key, merged result.
// An accepted request's result is registered into the output stage, behind any result still waiting there.
// Throughput: one request per cycle while in_ready is high; every key lane updates in parallel on a tick.
// A two-entry output stage lets one more request enter while a result waits.
// Reset (arst_n low, asynchronous): keys in init phase, counters and flags zero,
// debounce_limit 3, long_press_ticks 100, output stage empty.
`default_nettype none
module key_debounce_long_press #(
	parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] op,
	input wire logic [kdlp_pkg::LEVEL_W-1:0] key_levels,
	input wire logic [kdlp_pkg::INDEX_W-1:0] key_index,
	input wire logic [kdlp_pkg::FLAG_W-1:0] clear_mask,
	output logic out_valid,
	input wire logic out_ready,
	output logic was_pressed,
	output logic was_released,
	output logic is_on,
	output logic was_long,
	output logic was_changed,
	output logic any_changed
);
	logic [kdlp_pkg::CNT_W-1:0] debounce_limit_q;
	logic [kdlp_pkg::HOLD_W-1:0] long_press_q;
	logic accept;
	kdlp_pkg::cmd_t cmd;
	logic [NUM_KEYS-1:0] sel, changed_next;
	logic [NUM_KEYS-1:0][kdlp_pkg::FLAG_W-1:0] lane_flags;
	kdlp_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q <= kdlp_pkg::DEBOUNCE_RESET;
			long_press_q <= kdlp_pkg::LONG_PRESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kdlp_pkg::CFG_DEBOUNCE: debounce_limit_q <= cfg_data[kdlp_pkg::CNT_W-1:0];
				kdlp_pkg::CFG_LONG_PRESS: long_press_q <= cfg_data[kdlp_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;
	assign cmd.tick = accept && (op == kdlp_pkg::OP_TICK);
	assign cmd.clr_all = accept && (op == kdlp_pkg::OP_CLEAR_ALL);
	assign cmd.mask = clear_mask;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic level;
		if (k < kdlp_pkg::LEVEL_W) begin : g_in
			assign level = key_levels[k];
		end else begin : g_none
			assign level = 1'b0;
		end
		assign sel[k] = accept && (op == kdlp_pkg::OP_READ_CLEAR) && (32'(key_index) == k);

		kdlp_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.sel(sel[k]),
			.level(level),
			.debounce_limit(debounce_limit_q),
			.long_press_ticks(long_press_q),
			.flags(lane_flags[k]),
			.changed_next(changed_next[k])
		);
	end

	kdlp_merge #(
		.NUM_KEYS(NUM_KEYS)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.sel(sel),
		.lane_flags(lane_flags),
		.changed_next(changed_next),
		.ready(in_ready),
		.valid(out_valid),
		.pop_ready(out_ready),
		.res(res)
	);

	assign was_pressed = res.flags[kdlp_pkg::FL_PRESSED];
	assign was_released = res.flags[kdlp_pkg::FL_RELEASED];
	assign is_on = res.flags[kdlp_pkg::FL_ON];
	assign was_long = res.flags[kdlp_pkg::FL_LONG];
	assign was_changed = res.flags[kdlp_pkg::FL_CHANGED];
	assign any_changed = res.any_changed;
endmodule
`default_nettype wire

FILE: tb/key_debounce_long_press_tb.sv
// Self-checking testbench for the key bank debouncer with long-press detection.
`timescale 1ns / 100ps

module key_debounce_long_press_tb;
	localparam int NUM_KEYS_DEF = kdlp_pkg::NUM_KEYS_DEF;
	localparam int LEVEL_W = kdlp_pkg::LEVEL_W;
	localparam int INDEX_W = kdlp_pkg::INDEX_W;
	localparam int FLAG_W = kdlp_pkg::FLAG_W;
	localparam int CNT_W = kdlp_pkg::CNT_W;
	localparam int HOLD_W = kdlp_pkg::HOLD_W;
	localparam int CFG_DATA_W = kdlp_pkg::CFG_DATA_W;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_CYCLES = 3000;
	localparam int LONG_HOLD_CYCLES = 80;

	typedef struct packed {
		logic [1:0] op;
		logic [LEVEL_W-1:0] levels;
		logic [INDEX_W-1:0] index;
		logic [FLAG_W-1:0] mask;
	} key_request_t;

	typedef struct packed {
		logic was_pressed;
		logic was_released;
		logic is_on;
		logic was_long;
		logic was_changed;
		logic any_changed;
	} flag_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [LEVEL_W-1:0] key_levels = '0;
	logic [INDEX_W-1:0] key_index = '0;
	logic [FLAG_W-1:0] clear_mask = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic was_pressed;
	logic was_released;
	logic is_on;
	logic was_long;
	logic was_changed;
	logic any_changed;

	key_debounce_long_press i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.key_levels(key_levels),
		.key_index(key_index),
		.clear_mask(clear_mask),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.was_pressed(was_pressed),
		.was_released(was_released),
		.is_on(is_on),
		.was_long(was_long),
		.was_changed(was_changed),
		.any_changed(any_changed)
	);

	// Predicted key bank state and its settings.
	kdlp_pkg::phase_t key_state [NUM_KEYS_DEF];
	logic [CNT_W-1:0] steady_ticks [NUM_KEYS_DEF];
	logic [HOLD_W-1:0] held_ticks [NUM_KEYS_DEF];
	logic [FLAG_W-1:0] key_flags [NUM_KEYS_DEF];
	logic [CNT_W-1:0] limit_ticks;
	logic [HOLD_W-1:0] long_ticks;

	key_request_t key_requests [$];
	flag_report_t flag_reports [$];
	key_request_t cur_req;
	logic [LEVEL_W-1:0] held_levels = '0;
	int errors = 0;
	int results_seen = 0;
	int send_gap = 0;
	int send_burst = 0;
	int rcv_gap = 0;
	int rcv_burst = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] cnt);
		return (cnt == '1) ? cnt : cnt + 1'b1;
	endfunction

	function automatic void tick_key(int k, logic level);
		case (key_state[k])
			kdlp_pkg::PH_IDLE: begin
				steady_ticks[k] = level ? sat_inc(steady_ticks[k]) : '0;
				if (steady_ticks[k] > limit_ticks) begin
					key_flags[k][kdlp_pkg::FL_PRESSED] = 1'b1;
					key_flags[k][kdlp_pkg::FL_ON] = 1'b1;
					key_flags[k][kdlp_pkg::FL_CHANGED] = 1'b1;
					held_ticks[k] = '0;
					steady_ticks[k] = '0;
					key_state[k] = kdlp_pkg::PH_ON;
				end
			end
			kdlp_pkg::PH_ON: begin
				if (held_ticks[k] < long_ticks) begin
					held_ticks[k] = held_ticks[k] + 1'b1;
					if (held_ticks[k] == long_ticks) begin
						key_flags[k][kdlp_pkg::FL_LONG] = 1'b1;
						key_flags[k][kdlp_pkg::FL_CHANGED] = 1'b1;
					end
				end
				steady_ticks[k] = !level ? sat_inc(steady_ticks[k]) : '0;
				if (steady_ticks[k] > limit_ticks) begin
					key_flags[k][kdlp_pkg::FL_RELEASED] = 1'b1;
					key_flags[k][kdlp_pkg::FL_CHANGED] = 1'b1;
					key_flags[k][kdlp_pkg::FL_ON] = 1'b0;
					held_ticks[k] = '0;
					steady_ticks[k] = '0;
					key_state[k] = kdlp_pkg::PH_IDLE;
				end
			end
			default: key_state[k] = kdlp_pkg::PH_IDLE;
		endcase
	endfunction

	function automatic flag_report_t advance_keys(key_request_t r);
		flag_report_t rep;
		logic [FLAG_W-1:0] prior;
		logic [FLAG_W-1:0] hit;
		prior = '0;
		rep = '0;
		case (r.op)
			kdlp_pkg::OP_TICK: begin
				for (int k = 0; k < NUM_KEYS_DEF; k++)
					tick_key(k, (k < LEVEL_W) ? r.levels[k] : 1'b0);
			end
			kdlp_pkg::OP_READ_CLEAR: begin
				if (r.index < NUM_KEYS_DEF) begin
					prior = key_flags[r.index];
					hit = prior & r.mask;
					key_flags[r.index] = prior & ~hit;
					// Clearing any real event also retires the changed flag.
					if (|hit[kdlp_pkg::FL_LONG:kdlp_pkg::FL_PRESSED])
						key_flags[r.index][kdlp_pkg::FL_CHANGED] = 1'b0;
				end
			end
			kdlp_pkg::OP_CLEAR_ALL: begin
				for (int k = 0; k < NUM_KEYS_DEF; k++)
					key_flags[k] = '0;
			end
			default: ;
		endcase
		rep.was_pressed = prior[kdlp_pkg::FL_PRESSED];
		rep.was_released = prior[kdlp_pkg::FL_RELEASED];
		rep.is_on = prior[kdlp_pkg::FL_ON];
		rep.was_long = prior[kdlp_pkg::FL_LONG];
		rep.was_changed = prior[kdlp_pkg::FL_CHANGED];
		for (int k = 0; k < NUM_KEYS_DEF; k++)
			rep.any_changed |= key_flags[k][kdlp_pkg::FL_CHANGED];
		return rep;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(3, 1);
		else if (roll < 97)
			return $urandom_range(10, 4);
		else
			return $urandom_range(40, 15);
	endfunction

	function automatic void check_bit(string name, logic want, logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
			errors++;
		end
	endfunction

	// Request driver: valid stays up with a stable payload until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				flag_reports.push_back(advance_keys(cur_req));
				if (send_burst > 0) begin
					send_burst--;
					send_gap = 0;
				end else begin
					send_gap = pick_gap();
					if ($urandom_range(39) == 0)
						send_burst = 30;
				end
			end
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (key_requests.size() > 0) begin
				cur_req = key_requests.pop_front();
				in_valid <= 1'b1;
				op <= cur_req.op;
				key_levels <= cur_req.levels;
				key_index <= cur_req.index;
				clear_mask <= cur_req.mask;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (flag_reports.size() == 0) begin
					$display("%0t: result with no request outstanding", $time);
					errors++;
				end else begin
					flag_report_t want;
					want = flag_reports.pop_front();
					check_bit("was_pressed", want.was_pressed, was_pressed);
					check_bit("was_released", want.was_released, was_released);
					check_bit("is_on", want.is_on, is_on);
					check_bit("was_long", want.was_long, was_long);
					check_bit("was_changed", want.was_changed, was_changed);
					check_bit("any_changed", want.any_changed, any_changed);
				end
				results_seen++;
				// Now and then hold off long enough for the block to back up.
				if (results_seen % 300 == 150)
					stall_left = LONG_HOLD_CYCLES;
				else if (rcv_burst > 0)
					rcv_burst--;
				else begin
					rcv_gap = pick_gap();
					if ($urandom_range(39) == 0)
						rcv_burst = 30;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (rcv_gap > 0) begin
				rcv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("Test completed with failures");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic queue_request(logic [1:0] code, logic [LEVEL_W-1:0] levels,
			logic [INDEX_W-1:0] index, logic [FLAG_W-1:0] mask);
		key_request_t r;
		r.op = code;
		r.levels = levels;
		r.index = index;
		r.mask = mask;
		key_requests.push_back(r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (key_requests.size() != 0 || in_valid || flag_reports.size() != 0)
			@(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_cfg(kdlp_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			kdlp_pkg::CFG_DEBOUNCE: limit_ticks = value[CNT_W-1:0];
			kdlp_pkg::CFG_LONG_PRESS: long_ticks = value;
			default: ;
		endcase
	endtask

	// Keys follow slowly changing held levels, with the odd one-tick bounce.
	task automatic queue_random(int count, int tick_pct, int toggle_den, int bounce_pct);
		int roll;
		logic [LEVEL_W-1:0] noise;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < tick_pct) begin
				for (int k = 0; k < LEVEL_W; k++)
					if ($urandom_range(toggle_den - 1) == 0)
						held_levels[k] = ~held_levels[k];
				noise = ($urandom_range(99) < bounce_pct) ? LEVEL_W'($urandom) : '0;
				queue_request(kdlp_pkg::OP_TICK, held_levels ^ noise, INDEX_W'($urandom),
					FLAG_W'($urandom));
			end else begin
				roll = $urandom_range(19);
				if (roll < 15)
					queue_request(kdlp_pkg::OP_READ_CLEAR, LEVEL_W'($urandom),
						INDEX_W'($urandom_range(15)), FLAG_W'($urandom));
				else if (roll < 18)
					queue_request(kdlp_pkg::OP_CLEAR_ALL, LEVEL_W'($urandom),
						INDEX_W'($urandom), FLAG_W'($urandom));
				else
					queue_request(OP_UNUSED, LEVEL_W'($urandom), INDEX_W'($urandom),
						FLAG_W'($urandom));
			end
		end
	endtask

	// Two chunks with a full drain between them, so the sender also pauses mid-phase.
	task automatic random_phase(int count, int tick_pct, int toggle_den, int bounce_pct);
		queue_random(count / 2, tick_pct, toggle_den, bounce_pct);
		wait_drained();
		queue_random(count - count / 2, tick_pct, toggle_den, bounce_pct);
		wait_drained();
	endtask

	initial begin
		for (int k = 0; k < NUM_KEYS_DEF; k++) begin
			key_state[k] = kdlp_pkg::PH_INIT;
			steady_ticks[k] = '0;
			held_ticks[k] = '0;
			key_flags[k] = '0;
		end
		limit_ticks = kdlp_pkg::DEBOUNCE_RESET;
		long_ticks = kdlp_pkg::LONG_PRESS_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset settings.
		queue_request(OP_UNUSED, '1, 4'd15, '1);
		queue_request(kdlp_pkg::OP_READ_CLEAR, '0, 4'd0, '1);
		queue_request(kdlp_pkg::OP_TICK, '1, 4'd0, '0);
		repeat (4) queue_request(kdlp_pkg::OP_TICK, '1, 4'd0, '0);
		queue_request(kdlp_pkg::OP_READ_CLEAR, '0, 4'd0, '0);
		// Clearing a flag that is not set must leave changed alone.
		queue_request(kdlp_pkg::OP_READ_CLEAR, '0, 4'd1, FLAG_W'(1 << kdlp_pkg::FL_RELEASED));
		queue_request(kdlp_pkg::OP_READ_CLEAR, '0, 4'd1, FLAG_W'(1 << kdlp_pkg::FL_CHANGED));
		queue_request(kdlp_pkg::OP_READ_CLEAR, '0, 4'd13, FLAG_W'(1 << kdlp_pkg::FL_PRESSED));
		queue_request(kdlp_pkg::OP_READ_CLEAR, '1, 4'd14, '1);
		queue_request(kdlp_pkg::OP_READ_CLEAR, '1, 4'd15, '1);
		queue_request(OP_UNUSED, '0, 4'd0, '0);
		repeat (4) queue_request(kdlp_pkg::OP_TICK, '0, 4'd0, '0);
		queue_request(kdlp_pkg::OP_READ_CLEAR, '0, 4'd2, '1);
		queue_request(kdlp_pkg::OP_CLEAR_ALL, '0, 4'd0, '0);
		queue_request(kdlp_pkg::OP_READ_CLEAR, '0, 4'd3, '1);
		queue_request(kdlp_pkg::OP_TICK, 14'h2AAA, 4'd0, '0);
		queue_request(kdlp_pkg::OP_TICK, 14'h1555, 4'd0, '0);
		queue_request(kdlp_pkg::OP_TICK, 14'h2AAA, 4'd0, '0);
		queue_request(kdlp_pkg::OP_READ_CLEAR, '0, 4'd5,
			FLAG_W'((1 << kdlp_pkg::FL_ON) | (1 << kdlp_pkg::FL_LONG)));
		wait_drained();

		write_cfg(kdlp_pkg::CFG_DEBOUNCE, 16'd0);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS, 16'd1);
		random_phase(150, 70, 6, 10);

		write_cfg(kdlp_pkg::CFG_DEBOUNCE, 16'd1);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS, 16'd0);
		random_phase(150, 70, 8, 15);

		write_cfg(kdlp_pkg::CFG_DEBOUNCE, 16'd2);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS, 16'd6);
		random_phase(180, 75, 12, 10);

		// Widest settings: long steady stretches are needed to get past the debounce.
		write_cfg(kdlp_pkg::CFG_DEBOUNCE, 16'd254);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS, 16'hFFFF);
		random_phase(300, 97, 1000, 0);

		write_cfg(kdlp_pkg::CFG_DEBOUNCE, 16'd5);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS, 16'd20);
		random_phase(140, 85, 60, 5);

		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
